// ===== hw/rtl/filled_circle_column_span_assert.svh =====
// Assertion macros shared by the circle column span RTL.
// Depends on nothing; files that check their logic include this header.
`ifndef FILLED_CIRCLE_COLUMN_SPAN_ASSERT_SVH
`define FILLED_CIRCLE_COLUMN_SPAN_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FCCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fccs check failed");

// Next-cycle implication, disabled while in reset.
`define FCCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fccs check failed");

`endif

// ===== hw/rtl/fccs_pkg.sv =====
// Shared constants and types of the circle column span block.
// Depends on nothing; used by the register file and the top level.
`default_nettype none

package fccs_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned SCREEN_WIDTH_RESET  = 800;
  localparam int unsigned SCREEN_HEIGHT_RESET = 600;

  typedef enum logic [0:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== hw/rtl/fccs_regs.sv =====
// Screen size registers behind the APB-style configuration port.
// Depends on fccs_pkg for address width, data width and register indexes.
`default_nettype none

module fccs_regs import fccs_pkg::*; #(
  parameter int unsigned CB = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CB:0]           screen_width_o,
  output logic [CB:0]           screen_height_o
);

  logic [CB:0] width_q, width_d;
  logic [CB:0] height_q, height_d;
  reg_idx_e    idx;
  logic        wr_en;

  assign idx   = reg_idx_e'(paddr[2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (idx)
        REG_SCREEN_WIDTH:  width_d  = pwdata[CB:0];
        REG_SCREEN_HEIGHT: height_d = pwdata[CB:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SCREEN_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_SCREEN_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= (CB+1)'(SCREEN_WIDTH_RESET);
      height_q <= (CB+1)'(SCREEN_HEIGHT_RESET);
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign screen_width_o  = width_q;
  assign screen_height_o = height_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fccs_front.sv =====
// Entry stage: radicand r*r - d*d, absolute column and sign of the radicand.
// Depends on nothing; feeds the first square-root cell.
`default_nettype none

module fccs_front #(
  parameter int unsigned CB = 10,
  parameter int unsigned PW = 2*CB + 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [CB-1:0]      center_x_i,
  input  logic [CB-1:0]      center_y_i,
  input  logic [CB-1:0]      circle_radius_i,
  input  logic signed [CB:0] column_offset_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [2*CB-1:0]    rem_o,
  output logic [PW-1:0]      pay_o
);

  logic                  valid_q;
  logic                  en;
  logic [CB:0]           d_abs;
  logic [2*CB-1:0]       rr;
  logic [2*CB+1:0]       dd;
  logic signed [2*CB+2:0] diff;
  logic                  neg;
  logic signed [CB+1:0]  x;
  logic [2*CB-1:0]       rem_d, rem_q;
  logic [PW-1:0]         pay_d, pay_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    d_abs = column_offset_i[CB] ? (CB+1)'(-column_offset_i) : column_offset_i;
    rr    = circle_radius_i * circle_radius_i;
    dd    = d_abs * d_abs;
    diff  = $signed({3'b000, rr}) - $signed({1'b0, dd});
    neg   = diff[2*CB+2];
    rem_d = neg ? '0 : diff[2*CB-1:0];
    x     = $signed({2'b00, center_x_i}) + (CB+2)'(column_offset_i);
    pay_d = {neg, x, center_y_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      rem_q <= rem_d;
      pay_q <= pay_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign pay_o   = pay_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fccs_cell.sv =====
// One square-root cell: settles root bit BIT and passes the item on.
// Depends on nothing; a row of these forms the root pipeline.
`default_nettype none

module fccs_cell #(
  parameter int unsigned CB  = 10,
  parameter int unsigned BIT = 0,
  parameter int unsigned PW  = 2*CB + 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [2*CB-1:0] rem_i,
  input  logic [CB-1:0]   root_i,
  input  logic [PW-1:0]   pay_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [2*CB-1:0] rem_o,
  output logic [CB-1:0]   root_o,
  output logic [PW-1:0]   pay_o
);

  localparam int unsigned TW = 2*CB + 1;

  logic            valid_q;
  logic            en;
  logic [TW-1:0]   trial;
  logic            take;
  logic [2*CB-1:0] rem_d, rem_q;
  logic [CB-1:0]   root_d, root_q;
  logic [PW-1:0]   pay_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    trial  = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    take   = {1'b0, rem_i} >= trial;
    rem_d  = take ? rem_i - trial[2*CB-1:0] : rem_i;
    root_d = take ? (root_i | (CB'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fccs_tail.sv =====
// Exit stage: span ends from the root, screen clipping, result register.
// Depends on nothing; takes the last cell's output and the screen size.
`default_nettype none

module fccs_tail #(
  parameter int unsigned CB = 10,
  parameter int unsigned PW = 2*CB + 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [2*CB-1:0] rem_i,
  input  logic [CB-1:0]   root_i,
  input  logic [PW-1:0]   pay_i,
  input  logic [CB:0]     screen_width_i,
  input  logic [CB:0]     screen_height_i,
  output logic            valid_o,
  input  logic            ready_i,
  output logic [CB-1:0]   column_x_o,
  output logic [CB-1:0]   row_top_o,
  output logic [CB-1:0]   row_bottom_o,
  output logic            span_valid_o
);

  localparam logic [CB:0] Limit = (CB+1)'(1) << CB;

  logic                 valid_q;
  logic                 en;
  logic                 neg;
  logic signed [CB+1:0] x;
  logic [CB-1:0]        cy;
  logic [CB:0]          w_eff, h_eff;
  logic signed [CB+1:0] top, bot, top_c, bot_c, h_m1;
  logic                 x_ok, ok;
  logic [CB-1:0]        col_d, col_q, top_d, top_q, bot_d, bot_q;
  logic                 span_d, span_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_comb begin
    {neg, x, cy} = pay_i;
    w_eff = (screen_width_i > Limit) ? Limit : screen_width_i;
    h_eff = (screen_height_i > Limit) ? Limit : screen_height_i;
    top   = $signed({2'b00, cy}) - $signed({2'b00, root_i});
    bot   = $signed({2'b00, cy}) + $signed({2'b00, root_i})
            + $signed((CB+2)'(rem_i != '0));
    h_m1  = $signed({1'b0, h_eff}) - $signed((CB+2)'(1));
    top_c = top[CB+1] ? '0 : top;
    bot_c = (bot > h_m1) ? h_m1 : bot;
    x_ok  = !x[CB+1] && (x[CB:0] < w_eff);
    ok    = !neg && x_ok && !(top_c > bot_c);
    col_d  = ok ? x[CB-1:0] : '0;
    top_d  = ok ? top_c[CB-1:0] : '0;
    bot_d  = ok ? bot_c[CB-1:0] : '0;
    span_d = ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      col_q  <= col_d;
      top_q  <= top_d;
      bot_q  <= bot_d;
      span_q <= span_d;
    end
  end

  assign valid_o      = valid_q;
  assign column_x_o   = col_q;
  assign row_top_o    = top_q;
  assign row_bottom_o = bot_q;
  assign span_valid_o = span_q;

endmodule

`default_nettype wire

// ===== hw/rtl/filled_circle_column_span.sv =====
// Filled circle column span: one column of a filled circle per transaction.
// Depends on fccs_pkg, fccs_regs, fccs_front, fccs_cell, fccs_tail and the assert header.
//
// Input channel (in_valid_i/in_ready_o) carries centre, radius and column
// offset; output channel (out_valid_o/out_ready_i) returns column, top row,
// bottom row and span_valid. Outputs other than span_valid read zero when
// the span is empty or off screen.
// The pipeline has one entry stage forming r*r - d*d, one cell per root bit in
// the square-root chain and one clipping stage that is also the output register.
// Throughput is one transaction per cycle while out_ready_i stays high; every
// stage has its own valid bit, so bubbles close up.
// When the receiver stalls, the result holds and the chain keeps filling
// until every stage is full, then in_ready_o drops.
// Reset empties all stages and sets the screen to 800 by 600. The APB port
// (pready always high) holds screen_width at 0x0 and screen_height at 0x4;
// write it only while no transaction is in flight.
`default_nettype none

module filled_circle_column_span import fccs_pkg::*; #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [COORD_BITS-1:0]   center_x_i,
  input  logic [COORD_BITS-1:0]   center_y_i,
  input  logic [COORD_BITS-1:0]   circle_radius_i,
  input  logic signed [COORD_BITS:0] column_offset_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [COORD_BITS-1:0]   column_x_o,
  output logic [COORD_BITS-1:0]   row_top_o,
  output logic [COORD_BITS-1:0]   row_bottom_o,
  output logic                    span_valid_o
);

`include "filled_circle_column_span_assert.svh"

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned PW = 2*CB + 3;

  logic [CB:0]     screen_width, screen_height;
  logic            ch_valid [CB+1];
  logic            ch_ready [CB+1];
  logic [2*CB-1:0] ch_rem   [CB+1];
  logic [CB-1:0]   ch_root  [CB+1];
  logic [PW-1:0]   ch_pay   [CB+1];

  fccs_regs #(.CB(CB)) u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .screen_width_o  (screen_width),
    .screen_height_o (screen_height)
  );

  fccs_front #(.CB(CB), .PW(PW)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (in_valid_i),
    .ready_o         (in_ready_o),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .circle_radius_i (circle_radius_i),
    .column_offset_i (column_offset_i),
    .valid_o         (ch_valid[0]),
    .ready_i         (ch_ready[0]),
    .rem_o           (ch_rem[0]),
    .pay_o           (ch_pay[0])
  );

  assign ch_root[0] = '0;

  for (genvar k = 0; k < CB; k++) begin : g_cell
    fccs_cell #(.CB(CB), .BIT(CB - 1 - k), .PW(PW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ch_valid[k]),
      .ready_o (ch_ready[k]),
      .rem_i   (ch_rem[k]),
      .root_i  (ch_root[k]),
      .pay_i   (ch_pay[k]),
      .valid_o (ch_valid[k+1]),
      .ready_i (ch_ready[k+1]),
      .rem_o   (ch_rem[k+1]),
      .root_o  (ch_root[k+1]),
      .pay_o   (ch_pay[k+1])
    );
  end

  fccs_tail #(.CB(CB), .PW(PW)) u_tail (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (ch_valid[CB]),
    .ready_o         (ch_ready[CB]),
    .rem_i           (ch_rem[CB]),
    .root_i          (ch_root[CB]),
    .pay_i           (ch_pay[CB]),
    .screen_width_i  (screen_width),
    .screen_height_i (screen_height),
    .valid_o         (out_valid_o),
    .ready_i         (out_ready_i),
    .column_x_o      (column_x_o),
    .row_top_o       (row_top_o),
    .row_bottom_o    (row_bottom_o),
    .span_valid_o    (span_valid_o)
  );

  `FCCS_ASSERT_IMPL(a_stall_only_on_full, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  `FCCS_ASSERT_IMPL(a_empty_span_zero, clk_i, rst_ni, out_valid_o && !span_valid_o, (column_x_o == '0) && (row_top_o == '0) && (row_bottom_o == '0))
  `FCCS_ASSERT_IMPL(a_span_ordered, clk_i, rst_ni, out_valid_o && span_valid_o, row_top_o <= row_bottom_o)
  `FCCS_ASSERT_NEXT(a_width_write, clk_i, rst_ni, psel && penable && pwrite && !paddr[2], screen_width == $past(pwdata[CB:0]))

endmodule

`default_nettype wire

// ===== test/tb_filled_circle_column_span.sv =====
// Testbench for the filled circle column span block: checks each span against its own
// integer model under random idling, back-pressure and several screen settings.
// Depends on fccs_pkg and the filled_circle_column_span RTL.
`default_nettype none

module tb_filled_circle_column_span import fccs_pkg::*;;

  localparam int COORD_BITS     = 10;
  localparam int REG_BITS       = COORD_BITS + 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 2 * (COORD_BITS + 2);
  localparam int HOLD_OFF_LEN   = 300;

  typedef struct packed {
    logic [COORD_BITS-1:0] column_x;
    logic [COORD_BITS-1:0] row_top;
    logic [COORD_BITS-1:0] row_bottom;
    logic                  span_valid;
  } span_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [COORD_BITS-1:0]  center_x_i;
  logic [COORD_BITS-1:0]  center_y_i;
  logic [COORD_BITS-1:0]  circle_radius_i;
  logic signed [COORD_BITS:0] column_offset_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [COORD_BITS-1:0]  column_x_o;
  logic [COORD_BITS-1:0]  row_top_o;
  logic [COORD_BITS-1:0]  row_bottom_o;
  logic                   span_valid_o;

  logic [REG_BITS-1:0] screen_w;
  logic [REG_BITS-1:0] screen_h;
  span_t pending_spans[$];
  bit    idle_en;
  int    hold_off_cycles;
  int    mismatches;
  int    columns_sent;
  int    spans_seen;
  int    visible_spans;
  int    screen_settings;

  filled_circle_column_span #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .circle_radius_i(circle_radius_i),
    .column_offset_i(column_offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .column_x_o     (column_x_o),
    .row_top_o      (row_top_o),
    .row_bottom_o   (row_bottom_o),
    .span_valid_o   (span_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint column_root(longint v);
    longint s;
    longint t;
    s = 0;
    for (int b = COORD_BITS + 1; b >= 0; b--) begin
      t = s | (longint'(1) << b);
      if (t * t <= v) s = t;
    end
    return s;
  endfunction

  function automatic span_t predict_span(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                                         logic [COORD_BITS-1:0] r,
                                         logic signed [COORD_BITS:0] d);
    longint w;
    longint h;
    longint rem;
    longint x;
    longint top;
    longint bot;
    longint root;
    span_t  res;
    w = longint'(screen_w);
    h = longint'(screen_h);
    if (w > (longint'(1) << COORD_BITS)) w = longint'(1) << COORD_BITS;
    if (h > (longint'(1) << COORD_BITS)) h = longint'(1) << COORD_BITS;
    rem = longint'(r) * longint'(r) - longint'(d) * longint'(d);
    x   = longint'(cx) + longint'(d);
    res = '0;
    if (rem >= 0) begin
      root = column_root(rem);
      top  = longint'(cy) - root;
      bot  = longint'(cy) + root;
      if (root * root != rem) bot = bot + 1;
      if (top < 0) top = 0;
      if (bot > h - 1) bot = h - 1;
      if (x >= 0 && x < w && top <= bot) begin
        res.column_x   = x[COORD_BITS-1:0];
        res.row_top    = top[COORD_BITS-1:0];
        res.row_bottom = bot[COORD_BITS-1:0];
        res.span_valid = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, span_t want, span_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: expected x=%0d top=%0d bot=%0d v=%0b,",
               what, want.column_x, want.row_top, want.row_bottom, want.span_valid,
               " got x=%0d top=%0d bot=%0d v=%0b",
               got.column_x, got.row_top, got.row_bottom, got.span_valid);
  endtask

  always @(posedge clk_i) begin
    span_t got;
    span_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{column_x_o, row_top_o, row_bottom_o, span_valid_o};
      spans_seen++;
      if (got.span_valid) visible_spans++;
      if (pending_spans.size() == 0) begin
        report_mismatch("unexpected transaction", '0, got);
      end else begin
        want = pending_spans.pop_front();
        if (got.column_x !== want.column_x || got.row_top !== want.row_top ||
            got.row_bottom !== want.row_bottom || got.span_valid !== want.span_valid)
          report_mismatch("span", want, got);
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_ready_i = 1'b0;
        hold_off_cycles--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i     = 1'b0;
        hold_off_cycles = $urandom_range(0, 7);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_screen_reg(reg_idx_e idx, logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] stored;
    stored  = APB_DATA_W'(value[REG_BITS-1:0]);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = APB_ADDR_W'(4 * int'(idx));
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== stored) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH register %s: expected %0d, read %0d", idx.name(), stored, prdata);
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (idx == REG_SCREEN_WIDTH) screen_w = value[REG_BITS-1:0];
    else screen_h = value[REG_BITS-1:0];
  endtask

  task automatic set_screen(logic [APB_DATA_W-1:0] w, logic [APB_DATA_W-1:0] h);
    write_screen_reg(REG_SCREEN_WIDTH, w);
    write_screen_reg(REG_SCREEN_HEIGHT, h);
    screen_settings++;
  endtask

  task automatic send_span(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                           logic [COORD_BITS-1:0] r, logic signed [COORD_BITS:0] d);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    center_x_i      = cx;
    center_y_i      = cy;
    circle_radius_i = r;
    column_offset_i = d;
    in_valid_i      = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_spans.push_back(predict_span(cx, cy, r, d));
    columns_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random_span();
    logic [COORD_BITS-1:0] r;
    int                    off;
    case ($urandom_range(0, 7))
      0, 1:    r = COORD_BITS'($urandom_range(0, 15));
      default: r = COORD_BITS'($urandom);
    endcase
    if ($urandom_range(0, 7) == 0) off = $urandom_range(0, 2047) - 1024;
    else off = $urandom_range(0, 2 * int'(r)) - int'(r);
    send_span(COORD_BITS'($urandom), COORD_BITS'($urandom), r, (COORD_BITS + 1)'(off));
  endtask

  task automatic settle_spans();
    in_valid_i = 1'b0;
    while (pending_spans.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_default_screen();
    send_span(0, 0, 0, 0);
    send_span(512, 300, 1023, 0);
    send_span(512, 300, 1023, -1023);
    send_span(512, 300, 1023, 1023);
    send_span(100, 100, 5, 5);
    send_span(100, 100, 5, 6);
    send_span(100, 100, 0, -1024);
    send_span(1023, 1023, 1023, -1024);
    send_span(100, 100, 5, 2);
    send_span(100, 100, 5, 3);
    send_span(3, 100, 20, -10);
    send_span(795, 100, 20, 10);
    send_span(400, 2, 50, 0);
    send_span(400, 590, 50, 0);
    send_span(400, 1000, 5, 0);
    send_span(799, 599, 0, 0);
    settle_spans();
  endtask

  task automatic test_screen_extremes();
    set_screen(1024, 1024);
    send_span(1023, 1023, 0, 0);
    send_span(512, 512, 1023, 511);
    settle_spans();
    set_screen(2047, 2047);
    send_span(1023, 1023, 1023, 0);
    send_span(0, 0, 1023, 1);
    settle_spans();
    set_screen(0, 600);
    send_span(0, 10, 5, 0);
    settle_spans();
    set_screen(800, 0);
    send_span(10, 0, 5, 0);
    settle_spans();
    set_screen(1, 1);
    send_span(0, 0, 0, 0);
    send_span(0, 1, 0, 0);
    send_span(1, 0, 1, -1);
    settle_spans();
  endtask

  task automatic test_random_screens();
    logic [REG_BITS-1:0] w;
    logic [REG_BITS-1:0] h;
    for (int phase = 0; phase < 10; phase++) begin
      w = REG_BITS'($urandom_range(1, 1024));
      h = REG_BITS'($urandom_range(1, 1024));
      if (phase == 0) begin
        w = REG_BITS'(SCREEN_WIDTH_RESET);
        h = REG_BITS'(SCREEN_HEIGHT_RESET);
      end else if ($urandom_range(0, 4) == 0) begin
        w = REG_BITS'($urandom);
        h = REG_BITS'($urandom);
      end
      set_screen(APB_DATA_W'(w), APB_DATA_W'(h));
      repeat (55) send_random_span();
      settle_spans();
    end
  endtask

  task automatic test_backpressure();
    set_screen(1024, 1024);
    idle_en = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    repeat (60) send_random_span();
    settle_spans();
  endtask

  task automatic test_full_rate();
    set_screen(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET);
    idle_en = 1'b0;
    repeat (60) send_random_span();
    settle_spans();
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    center_x_i      = '0;
    center_y_i      = '0;
    circle_radius_i = '0;
    column_offset_i = '0;
    screen_w        = REG_BITS'(SCREEN_WIDTH_RESET);
    screen_h        = REG_BITS'(SCREEN_HEIGHT_RESET);
    idle_en         = 1'b1;
    hold_off_cycles = 0;
    mismatches      = 0;
    columns_sent    = 0;
    spans_seen      = 0;
    visible_spans   = 0;
    screen_settings = 1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_screen();
    test_screen_extremes();
    test_random_screens();
    idle_en = 1'b1;
    test_backpressure();
    test_full_rate();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_spans.size() != 0) mismatches++;
    $display("Sent %0d columns, checked %0d spans (%0d visible) across %0d screen settings,",
             columns_sent, spans_seen, visible_spans, screen_settings);
    $display("with random idling, a long receiver hold-off and a full-rate stretch; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
